FILE: src/bss_pkg.sv
// Shared types, widths and codes for the sphere/box shell screen.
// No dependencies; imported by every module of the block.
package bss_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int FIELD_W   = 32;  // coordinate field width on the bus
  localparam int GAP_W     = 32;  // per-axis gap that still squares into 64 bits
  localparam int SQ_W      = 64;  // Q32.32 squares and distances
  localparam int FUNCS_W   = 6;
  localparam int KEPT_W    = 16;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int KIND_W    = 3;
  localparam int S_TDATA_W = 168;
  localparam int M_TDATA_W = 80;

  // request commands
  localparam logic [CMD_W-1:0] CMD_FIRST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHELL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_POINT    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_KEPT     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_BATCH = 2'd3;

  // what the pipeline carries for each request after the box stage
  localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd0;  // batch opened, count cleared
  localparam logic [KIND_W-1:0] KIND_WIDEN    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE     = 3'd2;  // unused command
  localparam logic [KIND_W-1:0] KIND_SHELL    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_BATCH = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic [2:0]         sat;    // z, y, x gap too wide to square
    logic [GAP_W-1:0]   gap_x;
    logic [GAP_W-1:0]   gap_y;
    logic [GAP_W-1:0]   gap_z;
    logic [SQ_W-1:0]    cutoff;
    logic [FUNCS_W-1:0] funcs;
  } gap_stage_t;

  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic [SQ_W-1:0]    sq_x;
    logic [SQ_W-1:0]    sq_y;
    logic [SQ_W-1:0]    sq_z;
    logic [SQ_W-1:0]    cutoff;
    logic [FUNCS_W-1:0] funcs;
  } sq_stage_t;

endpackage

FILE: src/bss_box_track.sv
// Bounding box state and per-axis gap from a shell center to the box.
// Depends on bss_pkg.
module bss_box_track #(
  parameter int COORD_WIDTH = bss_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            enable,
  input  logic                            in_valid,
  input  logic [bss_pkg::CMD_W-1:0]       cmd,
  input  logic signed [COORD_WIDTH-1:0]   x_coord,
  input  logic signed [COORD_WIDTH-1:0]   y_coord,
  input  logic signed [COORD_WIDTH-1:0]   z_coord,
  input  logic [bss_pkg::SQ_W-1:0]        cutoff_sq,
  input  logic [bss_pkg::FUNCS_W-1:0]     shell_funcs,
  output bss_pkg::gap_stage_t             gap
);
  import bss_pkg::*;

  localparam int DIFF_W = COORD_WIDTH + 1;

  typedef struct packed {
    logic             sat;
    logic [GAP_W-1:0] gap;
  } axis_gap_t;

  function automatic axis_gap_t axis_gap(input logic signed [COORD_WIDTH-1:0] c,
                                         input logic signed [COORD_WIDTH-1:0] lo,
                                         input logic signed [COORD_WIDTH-1:0] hi);
    logic signed [DIFF_W-1:0] d;
    logic [SQ_W-1:0]          wide;
    axis_gap_t                r;
    d = '0;
    if (c < lo) begin
      d = DIFF_W'(lo) - DIFF_W'(c);
    end else if (c > hi) begin
      d = DIFF_W'(c) - DIFF_W'(hi);
    end
    wide  = SQ_W'($unsigned(d));
    r.sat = |wide[SQ_W-1:GAP_W];
    r.gap = wide[GAP_W-1:0];
    return r;
  endfunction

  logic signed [COORD_WIDTH-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic signed [COORD_WIDTH-1:0] lo_x_next, lo_y_next, lo_z_next;
  logic signed [COORD_WIDTH-1:0] hi_x_next, hi_y_next, hi_z_next;
  logic                          batch_open, batch_open_next;
  logic [KIND_W-1:0]             kind_c;
  axis_gap_t                     gx, gy, gz;
  logic                          fire;

  logic               valid;
  logic [KIND_W-1:0]  kind;
  logic [2:0]         sat;
  logic [GAP_W-1:0]   gap_x, gap_y, gap_z;
  logic [SQ_W-1:0]    cutoff;
  logic [FUNCS_W-1:0] funcs;

  assign fire = enable && in_valid;
  assign gx   = axis_gap(x_coord, lo_x, hi_x);
  assign gy   = axis_gap(y_coord, lo_y, hi_y);
  assign gz   = axis_gap(z_coord, lo_z, hi_z);

  always_comb begin
    lo_x_next = lo_x;
    lo_y_next = lo_y;
    lo_z_next = lo_z;
    hi_x_next = hi_x;
    hi_y_next = hi_y;
    hi_z_next = hi_z;
    batch_open_next = batch_open;
    kind_c = KIND_IDLE;
    unique case (cmd)
      CMD_FIRST, CMD_MORE: begin
        if (cmd == CMD_FIRST || !batch_open) begin
          lo_x_next = x_coord;
          hi_x_next = x_coord;
          lo_y_next = y_coord;
          hi_y_next = y_coord;
          lo_z_next = z_coord;
          hi_z_next = z_coord;
          batch_open_next = 1'b1;
          kind_c = KIND_OPEN;
        end else begin
          if (x_coord < lo_x) lo_x_next = x_coord;
          if (x_coord > hi_x) hi_x_next = x_coord;
          if (y_coord < lo_y) lo_y_next = y_coord;
          if (y_coord > hi_y) hi_y_next = y_coord;
          if (z_coord < lo_z) lo_z_next = z_coord;
          if (z_coord > hi_z) hi_z_next = z_coord;
          kind_c = KIND_WIDEN;
        end
      end
      CMD_SHELL: begin
        kind_c = batch_open ? KIND_SHELL : KIND_NO_BATCH;
      end
      CMD_NONE: begin
        kind_c = KIND_IDLE;
      end
      default: begin
        kind_c = KIND_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_x <= '0;
      lo_y <= '0;
      lo_z <= '0;
      hi_x <= '0;
      hi_y <= '0;
      hi_z <= '0;
      batch_open <= 1'b0;
      valid <= 1'b0;
    end else if (enable) begin
      valid <= in_valid;
      if (in_valid) begin
        lo_x <= lo_x_next;
        lo_y <= lo_y_next;
        lo_z <= lo_z_next;
        hi_x <= hi_x_next;
        hi_y <= hi_y_next;
        hi_z <= hi_z_next;
        batch_open <= batch_open_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      kind   <= kind_c;
      sat    <= {gz.sat, gy.sat, gx.sat};
      gap_x  <= gx.gap;
      gap_y  <= gy.gap;
      gap_z  <= gz.gap;
      cutoff <= cutoff_sq;
      funcs  <= shell_funcs;
    end
  end

  assign gap = '{valid: valid, kind: kind, sat: sat, gap_x: gap_x, gap_y: gap_y,
                 gap_z: gap_z, cutoff: cutoff, funcs: funcs};

  a_open_after_point: assert property (@(posedge clk) disable iff (rst)
    fire && (cmd == CMD_FIRST || cmd == CMD_MORE) |=> batch_open)
    else $error("batch not open after a point");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    batch_open |-> (lo_x <= hi_x) && (lo_y <= hi_y) && (lo_z <= hi_z))
    else $error("box corners out of order");

  a_shell_keeps_box: assert property (@(posedge clk) disable iff (rst)
    fire && cmd == CMD_SHELL |=> $stable(lo_x) && $stable(hi_x) && $stable(batch_open))
    else $error("shell request changed the box");

endmodule

FILE: src/bss_square.sv
// Per-axis squared gaps, saturated where the gap exceeds 32 bits.
// Depends on bss_pkg.
module bss_square (
  input  logic                clk,
  input  logic                rst,
  input  logic                enable,
  input  bss_pkg::gap_stage_t gap,
  output bss_pkg::sq_stage_t  sq
);
  import bss_pkg::*;

  logic [SQ_W-1:0]    px, py, pz;
  logic               valid;
  logic [KIND_W-1:0]  kind;
  logic [SQ_W-1:0]    sq_x, sq_y, sq_z, cutoff;
  logic [FUNCS_W-1:0] funcs;

  assign px = SQ_W'(gap.gap_x) * SQ_W'(gap.gap_x);
  assign py = SQ_W'(gap.gap_y) * SQ_W'(gap.gap_y);
  assign pz = SQ_W'(gap.gap_z) * SQ_W'(gap.gap_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (enable) begin
      valid <= gap.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      kind   <= gap.kind;
      sq_x   <= gap.sat[0] ? '1 : px;
      sq_y   <= gap.sat[1] ? '1 : py;
      sq_z   <= gap.sat[2] ? '1 : pz;
      cutoff <= gap.cutoff;
      funcs  <= gap.funcs;
    end
  end

  assign sq = '{valid: valid, kind: kind, sq_x: sq_x, sq_y: sq_y, sq_z: sq_z,
                cutoff: cutoff, funcs: funcs};

endmodule

FILE: src/bss_accum.sv
// Distance sum, cutoff compare, kept-function total and result register.
// Depends on bss_pkg.
module bss_accum #(
  parameter int COUNT_WIDTH = bss_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enable,
  input  bss_pkg::sq_stage_t            sq,
  output logic                          out_valid,
  output logic [bss_pkg::STATUS_W-1:0]  status,
  output logic [bss_pkg::KEPT_W-1:0]    kept_funcs,
  output logic [bss_pkg::SQ_W-1:0]      dist_sq
);
  import bss_pkg::*;

  logic [SQ_W:0]          s1, s2;
  logic [SQ_W-1:0]        p1, dist_c;
  logic                   kept;
  logic [COUNT_WIDTH:0]   tsum;
  logic [COUNT_WIDTH-1:0] func_total, func_total_next;
  logic [STATUS_W-1:0]    status_c;
  logic [SQ_W-1:0]        dist_out;
  logic                   fire;

  assign fire   = enable && sq.valid;
  assign s1     = {1'b0, sq.sq_x} + {1'b0, sq.sq_y};
  assign p1     = s1[SQ_W] ? '1 : s1[SQ_W-1:0];
  assign s2     = {1'b0, p1} + {1'b0, sq.sq_z};
  assign dist_c = s2[SQ_W] ? '1 : s2[SQ_W-1:0];
  assign kept   = dist_c < sq.cutoff;
  assign tsum   = {1'b0, func_total} + (COUNT_WIDTH + 1)'(sq.funcs);

  always_comb begin
    func_total_next = func_total;
    status_c = STATUS_POINT;
    dist_out = '0;
    unique case (sq.kind)
      KIND_OPEN: begin
        func_total_next = '0;
      end
      KIND_SHELL: begin
        dist_out = dist_c;
        if (kept) begin
          status_c = STATUS_KEPT;
          func_total_next = tsum[COUNT_WIDTH] ? '1 : tsum[COUNT_WIDTH-1:0];
        end else begin
          status_c = STATUS_DROPPED;
        end
      end
      KIND_NO_BATCH: begin
        status_c = STATUS_NO_BATCH;
      end
      default: begin
        status_c = STATUS_POINT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      func_total <= '0;
      out_valid <= 1'b0;
    end else if (enable) begin
      out_valid <= sq.valid;
      if (sq.valid) begin
        func_total <= func_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      status     <= status_c;
      kept_funcs <= KEPT_W'(func_total_next);
      dist_sq    <= dist_out;
    end
  end

  a_point_dist_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_POINT || status == STATUS_NO_BATCH) |-> dist_sq == '0)
    else $error("nonzero distance on a point or orphan shell");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(fire) && $past(sq.kind) != KIND_OPEN
      |-> func_total >= $past(func_total))
    else $error("kept total fell without a new batch");

endmodule

FILE: src/bbox_sphere_shell_screen.sv
// Top level of the sphere/box shell screen: input register and pipeline wiring.
// Depends on bss_pkg, bss_box_track, bss_square and bss_accum.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the command (first point,
//   further point, shell test), s_tdata the point or shell center, the squared
//   cutoff and the shell size. Each request gives exactly one result on the m_
//   stream: m_tuser carries the status, m_tdata the kept-function total and the
//   squared center-to-box distance (Q32.32, saturating, zero for points).
//   Pipeline: input register, box/gap stage (min/max update and per-axis gap),
//   square stage (three 32x32 multipliers), sum/compare stage with the result
//   register. One request is taken every cycle unless the receiver stalls.
//   The box corners update in the gap stage, the kept total in the last stage,
//   so back-to-back points and shells see each other's effect in order.
//   A receiver stall holds all four stages; s_tready drops only while the
//   result register holds an untaken result, and rises with m_tready.
//   Synchronous reset empties the pipeline, closes the batch, zeroes the box and
//   the kept total.
module bbox_sphere_shell_screen #(
  parameter int COORD_WIDTH = bss_pkg::COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = bss_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // x_coord[31:0], y_coord[63:32], z_coord[95:64], cutoff_sq[159:96],
  // shell_funcs[165:160], zero pad[167:166]
  input  logic [bss_pkg::S_TDATA_W-1:0]   s_tdata,
  // cmd[1:0]
  input  logic [bss_pkg::CMD_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // kept_funcs[15:0], dist_sq[79:16]
  output logic [bss_pkg::M_TDATA_W-1:0]   m_tdata,
  // status[1:0]
  output logic [bss_pkg::STATUS_W-1:0]    m_tuser
);
  import bss_pkg::*;

  localparam int X_LO      = 0;
  localparam int Y_LO      = X_LO + FIELD_W;
  localparam int Z_LO      = Y_LO + FIELD_W;
  localparam int CUT_LO    = Z_LO + FIELD_W;
  localparam int FUNCS_LO  = CUT_LO + SQ_W;

  logic enable;

  // input register
  logic                          a_valid;
  logic [CMD_W-1:0]              a_cmd;
  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
  logic [SQ_W-1:0]               a_cutoff;
  logic [FUNCS_W-1:0]            a_funcs;

  gap_stage_t          gap;
  sq_stage_t           sq;
  logic [STATUS_W-1:0] status;
  logic [KEPT_W-1:0]   kept_funcs;
  logic [SQ_W-1:0]     dist_sq;

  // whole pipeline advances whenever the result register can take a new value
  assign enable   = !m_tvalid || m_tready;
  assign s_tready = enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (enable) begin
      a_valid <= s_tvalid;
    end
  end

  // coordinates narrow or zero-extend to COORD_WIDTH, then read as signed
  always_ff @(posedge clk) begin
    if (enable) begin
      a_cmd    <= s_tuser;
      a_x      <= COORD_WIDTH'($unsigned(s_tdata[X_LO +: FIELD_W]));
      a_y      <= COORD_WIDTH'($unsigned(s_tdata[Y_LO +: FIELD_W]));
      a_z      <= COORD_WIDTH'($unsigned(s_tdata[Z_LO +: FIELD_W]));
      a_cutoff <= s_tdata[CUT_LO +: SQ_W];
      a_funcs  <= s_tdata[FUNCS_LO +: FUNCS_W];
    end
  end

  bss_box_track #(.COORD_WIDTH(COORD_WIDTH)) u_box (
    .clk         (clk),
    .rst         (rst),
    .enable      (enable),
    .in_valid    (a_valid),
    .cmd         (a_cmd),
    .x_coord     (a_x),
    .y_coord     (a_y),
    .z_coord     (a_z),
    .cutoff_sq   (a_cutoff),
    .shell_funcs (a_funcs),
    .gap         (gap)
  );

  bss_square u_square (
    .clk    (clk),
    .rst    (rst),
    .enable (enable),
    .gap    (gap),
    .sq     (sq)
  );

  bss_accum #(.COUNT_WIDTH(COUNT_WIDTH)) u_accum (
    .clk        (clk),
    .rst        (rst),
    .enable     (enable),
    .sq         (sq),
    .out_valid  (m_tvalid),
    .status     (status),
    .kept_funcs (kept_funcs),
    .dist_sq    (dist_sq)
  );

  assign m_tdata = {dist_sq, kept_funcs};
  assign m_tuser = status;

endmodule
